// ===== rtl/smup_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smup_pkg
// Shared types, constants and helpers for the MIDI byte to USB-MIDI packer.
// ----------------------------------------------------------------------------
package smup_pkg;

    localparam logic [7:0] RT_MIN       = 8'hF8;
    localparam logic [7:0] SYS_BASE     = 8'hF0;
    localparam logic [7:0] SC_MTC       = 8'hF1;
    localparam logic [7:0] SC_SPP       = 8'hF2;
    localparam logic [7:0] SC_SONG_SEL  = 8'hF3;
    localparam logic [7:0] SC_TUNE_REQ  = 8'hF6;

    localparam logic [3:0] KIND_PROG    = 4'hC;
    localparam logic [3:0] KIND_CHPRESS = 4'hD;
    localparam logic [3:0] KIND_SYS     = 4'hF;

    localparam logic [3:0] CIN_SC_2B    = 4'h2;
    localparam logic [3:0] CIN_SC_3B    = 4'h3;
    localparam logic [3:0] CIN_SC_1B    = 4'h5;
    localparam logic [3:0] CIN_RT       = 4'hF;

    localparam logic [1:0] LEN_NONE     = 2'd0;
    localparam logic [1:0] LEN_ONE      = 2'd1;
    localparam logic [1:0] LEN_TWO      = 2'd2;
    localparam logic [1:0] LEN_THREE    = 2'd3;

    typedef enum logic [2:0] {
        FILL_NONE   = 3'd0,
        FILL_FIRST  = 3'd2,
        FILL_SECOND = 3'd3,
        FILL_DONE   = 3'd4
    } fill_t;

    typedef struct packed {
        logic [7:0] midi_byte_2;
        logic [7:0] midi_byte_1;
        logic [7:0] midi_byte_0;
        logic [3:0] code_index;
    } packet_t;

    typedef struct packed {
        logic    valid;
        packet_t pkt;
    } parse_res_t;

    function automatic logic [3:0] code_for_status(input logic [7:0] st);
        logic [3:0] cin;
        cin = st[7:4];
        if (cin == KIND_SYS) begin
            if (st == SC_MTC || st == SC_SONG_SEL) begin
                cin = CIN_SC_2B;
            end else if (st == SC_SPP) begin
                cin = CIN_SC_3B;
            end else begin
                cin = CIN_SC_1B;
            end
        end
        return cin;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/smup_in_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smup_in_stage
// Input register for received bytes; frees itself as the parser advances.
// ----------------------------------------------------------------------------
module smup_in_stage (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] rx_byte
    input  wire logic       advance,
    output logic            in_valid,
    output logic [7:0]      in_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign s_tready = !valid_reg || advance;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/smup_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smup_parser
// MIDI parse state and per-byte decision; yields at most one event packet.
// ----------------------------------------------------------------------------
module smup_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output smup_pkg::parse_res_t res
);

    logic [7:0]           held_status_reg,  held_status_next;
    logic [7:0]           held_first_reg,   held_first_next;
    logic [7:0]           held_second_reg,  held_second_next;
    smup_pkg::fill_t      fill_reg,         fill_next;
    logic [1:0]           msg_len_reg,      msg_len_next;
    logic [7:0]           running_reg,      running_next;
    logic                 done;

    always_comb begin
        held_status_next = held_status_reg;
        held_first_next  = held_first_reg;
        held_second_next = held_second_reg;
        fill_next        = fill_reg;
        msg_len_next     = msg_len_reg;
        running_next     = running_reg;
        done             = 1'b0;
        res              = '0;

        if (rx_byte >= smup_pkg::RT_MIN) begin
            res.valid           = 1'b1;
            res.pkt.code_index  = smup_pkg::CIN_RT;
            res.pkt.midi_byte_0 = rx_byte;
            res.pkt.midi_byte_1 = 8'h00;
            res.pkt.midi_byte_2 = 8'h00;
        end else begin
            if (rx_byte[7]) begin
                held_status_next = rx_byte;
                fill_next        = smup_pkg::FILL_FIRST;
                running_next     = (rx_byte < smup_pkg::SYS_BASE) ? rx_byte : 8'h00;
                case (rx_byte[7:4])
                    smup_pkg::KIND_PROG, smup_pkg::KIND_CHPRESS: begin
                        msg_len_next = smup_pkg::LEN_TWO;
                    end
                    smup_pkg::KIND_SYS: begin
                        if (rx_byte inside {smup_pkg::SC_MTC, smup_pkg::SC_SONG_SEL}) begin
                            msg_len_next = smup_pkg::LEN_TWO;
                        end else if (rx_byte == smup_pkg::SC_SPP) begin
                            msg_len_next = smup_pkg::LEN_THREE;
                        end else if (rx_byte == smup_pkg::SC_TUNE_REQ) begin
                            msg_len_next = smup_pkg::LEN_ONE;
                        end else begin
                            msg_len_next = smup_pkg::LEN_NONE;
                            fill_next    = smup_pkg::FILL_NONE;
                        end
                    end
                    default: begin
                        msg_len_next = smup_pkg::LEN_THREE;
                    end
                endcase
            end else begin
                case (fill_reg)
                    smup_pkg::FILL_FIRST: begin
                        held_first_next = rx_byte;
                        fill_next       = smup_pkg::FILL_SECOND;
                    end
                    smup_pkg::FILL_SECOND: begin
                        held_second_next = rx_byte;
                        fill_next        = smup_pkg::FILL_DONE;
                    end
                    default: begin
                    end
                endcase
            end

            done = (fill_next != smup_pkg::FILL_NONE) &&
                   (3'(fill_next) == ({1'b0, msg_len_next} + 3'd1));

            if (done) begin
                res.valid           = 1'b1;
                res.pkt.code_index  = smup_pkg::code_for_status(held_status_next);
                res.pkt.midi_byte_0 = held_status_next;
                res.pkt.midi_byte_1 = held_first_next;
                res.pkt.midi_byte_2 = held_second_next;
                fill_next = (running_next != 8'h00) ? smup_pkg::FILL_FIRST
                                                    : smup_pkg::FILL_NONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_status_reg <= 8'h00;
            held_first_reg  <= 8'h00;
            held_second_reg <= 8'h00;
            fill_reg        <= smup_pkg::FILL_NONE;
            msg_len_reg     <= smup_pkg::LEN_NONE;
            running_reg     <= 8'h00;
        end else if (step) begin
            held_status_reg <= held_status_next;
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
            fill_reg        <= fill_next;
            msg_len_reg     <= msg_len_next;
            running_reg     <= running_next;
        end
    end

`ifndef SYNTHESIS
    a_open_has_status: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != smup_pkg::FILL_NONE |-> held_status_reg[7])
        else $error("message open without a status byte");

    a_running_matches_held: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg != 8'h00 |-> (running_reg == held_status_reg && running_reg < smup_pkg::SYS_BASE))
        else $error("running status differs from held channel status");

    a_second_slot_len: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg == smup_pkg::FILL_SECOND |-> msg_len_reg == smup_pkg::LEN_THREE)
        else $error("second data slot open on a short message");

    a_reopen_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && done && running_next != 8'h00) |=> fill_reg == smup_pkg::FILL_FIRST)
        else $error("parse not reopened under running status");
`endif

endmodule
`default_nettype wire

// ===== rtl/smup_out_stage.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smup_out_stage
// Result register holding one event packet until the consumer takes it.
// ----------------------------------------------------------------------------
module smup_out_stage (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        advance,
    input  wire smup_pkg::parse_res_t res,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [3:0] code_index, [11:4] midi_byte_0,
                                        // [19:12] midi_byte_1, [27:20] midi_byte_2
);

    logic              valid_reg;
    logic              valid_next;
    smup_pkg::packet_t pkt_reg;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {4'h0, pkt_reg};

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = res.valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            pkt_reg <= res.pkt;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/serial_midi_to_usb_event_packer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_midi_to_usb_event_packer
// Packs received serial MIDI bytes into 4-byte USB-MIDI event packets.
// ----------------------------------------------------------------------------
// Takes one MIDI byte per cycle while the output is drained and gives one packet
// for each real-time byte and each completed message (running status supported);
// other bytes give nothing. A byte goes from the input register through the
// parser into the result register, from which its packet is offered on the
// result port; a new byte can be transferred every cycle as long as the result
// register is drained, and a stalled result register holds the input.
// ----------------------------------------------------------------------------
module serial_midi_to_usb_event_packer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [3:0] code_index, [11:4] midi_byte_0,
                                        // [19:12] midi_byte_1, [27:20] midi_byte_2
);

    logic                 in_valid;
    logic [7:0]           in_byte;
    logic                 advance;
    smup_pkg::parse_res_t res;

    assign advance = in_valid && (!m_tvalid || m_tready);

    smup_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_byte  (in_byte)
    );

    smup_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .rx_byte (in_byte),
        .res     (res)
    );

    smup_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire
